[sv/polyline_tube_frame_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the polyline tube frame block
// Shared implication and next-cycle checks, clocked on clk with arst_n.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_TUBE_FRAME_ASSERT_SVH
`define POLYLINE_TUBE_FRAME_ASSERT_SVH

// Same-cycle implication.
`define PTF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PTF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/ptf_pkg.sv]
// ----------------------------------------------------------------------------
// Polyline tube frame package
// Request and vertex types, fixed widths and shared control types.
// ----------------------------------------------------------------------------
package ptf_pkg;

	localparam int COORD_W  = 32;
	localparam int NORM_W   = 16;
	localparam int IDX_W    = 32;
	localparam int COLOR_W  = 24;
	localparam int PADDR_W  = 3;
	localparam int MUL_W    = 33;
	localparam int ACC_W    = 66;
	localparam int MAG_W    = 48;

	localparam logic [31:0] MIN_TSQ_RST = 32'd512;
	localparam logic        REG_MIN_TSQ = 1'b0;
	localparam logic signed [NORM_W-1:0] UNIT_NRM = NORM_W'(1 << (NORM_W - 2));

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [COLOR_W-1:0]        color_rgb;
		logic                      last_point;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic signed [COORD_W-1:0] tan_x;
		logic signed [COORD_W-1:0] tan_y;
		logic signed [COORD_W-1:0] tan_z;
		logic signed [NORM_W-1:0]  nrm_x;
		logic signed [NORM_W-1:0]  nrm_y;
		logic signed [NORM_W-1:0]  nrm_z;
		logic [COLOR_W-1:0]        vertex_color;
		logic [IDX_W-1:0]          vertex_index;
		logic                      last_vertex;
	} vertex_t;

	typedef enum logic [1:0] {MAC_HOLD, MAC_LOAD, MAC_ADD, MAC_SUB} mac_op_t;

	typedef struct packed {
		logic start;
		logic is_sqrt;
	} rd_ctl_t;

endpackage

[sv/ptf_mac.sv]
// ----------------------------------------------------------------------------
// Polyline tube frame multiply-accumulate unit
// One registered signed multiplier feeding a load/add/subtract accumulator.
// ----------------------------------------------------------------------------
module ptf_mac
	import ptf_pkg::*;
(
	input  logic                    clk,
	input  logic signed [MUL_W-1:0] a,
	input  logic signed [MUL_W-1:0] b,
	input  mac_op_t                 op,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [ACC_W-1:0] prod_s1;
	logic signed [ACC_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		case (op)
			MAC_LOAD: acc_q <= prod_s1;
			MAC_ADD:  acc_q <= acc_q + prod_s1;
			MAC_SUB:  acc_q <= acc_q - prod_s1;
			default:  acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;

endmodule

[sv/ptf_root_div.sv]
// ----------------------------------------------------------------------------
// Polyline tube frame root and divide unit
// Restoring square root (two bits a step) and division (one bit a step)
// sharing one subtractor.
// ----------------------------------------------------------------------------
module ptf_root_div
	import ptf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  rd_ctl_t     ctl,
	input  logic [63:0] x,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] res
);

	localparam logic [4:0] SQRT_LAST = 5'd31;
	localparam logic [4:0] DIV_LAST  = 5'd15;

	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [31:0] den_q;
	logic [63:0] xs_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        sqrt_q;
	logic        done_q;
	logic [33:0] r2;
	logic [33:0] trial;
	logic [33:0] diff;
	logic        ge;

	always_comb begin
		r2    = sqrt_q ? {rem_q[31:0], xs_q[63:62]} : {rem_q[32:0], xs_q[63]};
		trial = sqrt_q ? {root_q, 2'b01} : {2'b00, den_q};
		ge    = r2 >= trial;
		diff  = r2 - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			sqrt_q <= 1'b0;
		end else if (ctl.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			sqrt_q <= ctl.is_sqrt;
		end else if (run_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == (sqrt_q ? SQRT_LAST : DIV_LAST)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			root_q <= '0;
			den_q  <= den;
			rem_q  <= ctl.is_sqrt ? 34'd0 : x[49:16];
			xs_q   <= ctl.is_sqrt ? x : {x[15:0], 48'd0};
		end else if (run_q) begin
			rem_q  <= ge ? diff : r2;
			root_q <= {root_q[30:0], ge};
			xs_q   <= sqrt_q ? {xs_q[61:0], 2'b00} : {xs_q[62:0], 1'b0};
		end
	end

	assign done = done_q;
	assign res  = root_q;

endmodule

[sv/polyline_tube_frame.sv]
// ----------------------------------------------------------------------------
// Polyline tube frame generator
// Tangent, parallel-transported normal and running index for polyline points.
// ----------------------------------------------------------------------------
// Points enter on the point channel (valid/ready) and vertices leave on the
// vertex channel (valid/ready) through one output register. A vertex for a
// point is produced once the following point has arrived, so the request
// that carries last_point can give up to two vertices.
// The block works on one request at a time: point_ready is high only while
// the sequencer is idle. A point that emits a vertex passes through the
// one-bit-a-cycle magnitude scaler, the shared root/divide unit (a square
// root and three quotients) and the shared multiplier (up to seven sums of
// products). A vertex whose normal is kept unchanged skips the root and the
// quotients. Dropped points end after the squared length test.
// A stalled vertex receiver holds the output register; the sequencer then
// waits before it overwrites that register, and no new point is taken
// meanwhile. The APB port holds min_tangent_sq at byte address 0; it
// should be written only while the block is idle. Reset clears all held
// points, the index counter and sets min_tangent_sq to 512.
// ----------------------------------------------------------------------------
module polyline_tube_frame
	import ptf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               point_valid,
	output logic               point_ready,
	input  point_t             point,
	output logic               vertex_valid,
	input  logic               vertex_ready,
	output vertex_t            vertex
);

	`include "polyline_tube_frame_assert.svh"

	typedef enum logic [3:0] {
		S_IDLE, S_TAN, S_CHK, S_MAC, S_LOADT, S_SCALE, S_ROOT, S_DIV,
		S_KEEP, S_RES, S_SKIP, S_OUT
	} state_t;

	typedef enum logic [2:0] {PH_TSQ, PH_USQ, PH_PU, PH_V, PH_VSQ} phase_t;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] d);
		logic signed [31:0] r;
		if (d[32] != d[31]) begin
			r = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			r = d[31:0];
		end
		return r;
	endfunction

	function automatic logic [32:0] mag32(input logic signed [31:0] v);
		logic signed [32:0] e;
		e = {v[31], v};
		return e[32] ? 33'(-e) : 33'(e);
	endfunction

	// Control and held state.
	state_t              st_q;
	phase_t              ph_q;
	logic [2:0]          k_q;
	logic [1:0]          c_q;
	logic                idx_q;
	logic                pend_q;
	logic                scv_q;
	logic [1:0]          seen_q;
	logic                nv_q;
	logic [IDX_W-1:0]    vcnt_q;
	logic [31:0]         min_tsq_q;
	logic                ovld_q;

	// Datapath registers.
	point_t              in_q;
	logic signed [31:0]  old_q [3];
	logic signed [31:0]  mid_q [3];
	logic [COLOR_W-1:0]  mid_col_q;
	logic signed [15:0]  prior_q [3];
	logic signed [31:0]  t_q [3];
	logic signed [31:0]  epos_q [3];
	logic [COLOR_W-1:0]  ecol_q;
	logic signed [15:0]  u_q [3];
	logic [31:0]         tt_q;
	logic signed [31:0]  pt_q;
	logic [31:0]         len_q;
	logic [2:0]          sg_q;
	logic [MAG_W-1:0]    mg_q [3];
	logic signed [15:0]  n_q [3];
	vertex_t             res_q;
	vertex_t             out_q;

	// Combinational signals.
	logic signed [31:0]  p_in [3];
	logic signed [31:0]  tan_c [3];
	logic                small_c;
	logic                zero_c;
	logic                hi_c;
	logic                lo_c;
	logic                push_ok;
	logic                out_load;
	logic                cfg_wr;
	logic                accept;
	logic [1:0]          j;
	logic [1:0]          cn;
	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	mac_op_t             mac_op;
	logic signed [ACC_W-1:0] acc;
	logic [ACC_W-1:0]    acc_mag;
	rd_ctl_t             rd_ctl;
	logic [63:0]         rd_x;
	logic [31:0]         rd_den;
	logic                rd_done;
	logic [31:0]         rd_res;
	logic [15:0]         q16;
	logic                mac_end;

	assign p_in[0] = in_q.pos_x;
	assign p_in[1] = in_q.pos_y;
	assign p_in[2] = in_q.pos_z;

	// Tangent: one-sided at the ends, halved central difference in between.
	always_comb begin
		logic signed [32:0] d_old;
		logic signed [32:0] d_mid;
		logic signed [32:0] d_half;
		for (int i = 0; i < 3; i++) begin
			d_old  = 33'(p_in[i]) - 33'(old_q[i]);
			d_mid  = 33'(p_in[i]) - 33'(mid_q[i]);
			d_half = (d_old + $signed({32'd0, d_old[32]})) >>> 1;
			if (idx_q) begin
				tan_c[i] = sat33(d_old);
			end else if (seen_q == 2'd1) begin
				tan_c[i] = sat33(d_mid);
			end else begin
				tan_c[i] = sat33(d_half);
			end
		end
	end

	// Scaler tests: zero vector, above range, below range.
	always_comb begin
		small_c = 1'b1;
		zero_c  = 1'b1;
		hi_c    = 1'b0;
		lo_c    = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (mag32(t_q[i]) >= 33'd65536) begin
				small_c = 1'b0;
			end
			if (mg_q[i] != '0) begin
				zero_c = 1'b0;
			end
			if (scv_q) begin
				hi_c = hi_c | (|mg_q[i][MAG_W-1:29]);
				lo_c = lo_c & (mg_q[i][MAG_W-1:28] == '0);
			end else begin
				hi_c = hi_c | (|mg_q[i][MAG_W-1:15]);
				lo_c = lo_c & (mg_q[i][MAG_W-1:14] == '0);
			end
		end
	end

	// Multiplier operand selection and accumulator control.
	always_comb begin
		j       = (k_q[1:0] == 2'd3) ? 2'd0 : k_q[1:0];
		mul_a   = '0;
		mul_b   = '0;
		mac_op  = MAC_HOLD;
		mac_end = 1'b0;
		if (st_q == S_MAC) begin
			case (ph_q)
				PH_TSQ: begin
					mul_a = MUL_W'(t_q[j]);
					mul_b = MUL_W'(t_q[j]);
				end
				PH_USQ: begin
					mul_a = MUL_W'(u_q[j]);
					mul_b = MUL_W'(u_q[j]);
				end
				PH_PU: begin
					mul_a = MUL_W'(prior_q[j]);
					mul_b = MUL_W'(u_q[j]);
				end
				PH_V: begin
					if (k_q == 3'd0) begin
						mul_a = MUL_W'(prior_q[c_q]);
						mul_b = $signed({1'b0, tt_q});
					end else begin
						mul_a = MUL_W'(pt_q);
						mul_b = MUL_W'(u_q[c_q]);
					end
				end
				PH_VSQ: begin
					mul_a = sg_q[j] ? -$signed({3'd0, mg_q[j][29:0]})
					                : $signed({3'd0, mg_q[j][29:0]});
					mul_b = mul_a;
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
			if (ph_q == PH_V) begin
				mac_end = k_q == 3'd3;
				if (k_q == 3'd1) begin
					mac_op = MAC_LOAD;
				end else if (k_q == 3'd2) begin
					mac_op = MAC_SUB;
				end
			end else begin
				mac_end = k_q == 3'd4;
				if (k_q == 3'd1) begin
					mac_op = MAC_LOAD;
				end else if (k_q == 3'd2 || k_q == 3'd3) begin
					mac_op = MAC_ADD;
				end
			end
		end
	end

	ptf_mac u_mac (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.op  (mac_op),
		.acc (acc)
	);

	assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

	// Root and divide requests: the root follows the sum of squared v, and
	// each quotient starts as soon as the previous result is in.
	always_comb begin
		cn             = (st_q == S_ROOT) ? 2'd0 : c_q + 2'd1;
		rd_den         = (st_q == S_ROOT) ? rd_res : len_q;
		rd_ctl.is_sqrt = (st_q == S_MAC);
		rd_ctl.start   = ((st_q == S_MAC) && (ph_q == PH_VSQ) && mac_end) ||
		                 (rd_done && (st_q == S_ROOT)) ||
		                 (rd_done && (st_q == S_DIV) && (c_q != 2'd2));
		if (st_q == S_MAC) begin
			rd_x = acc[63:0];
		end else begin
			rd_x = (64'(mg_q[cn][28:0]) << 14) + 64'(rd_den[31:1]);
		end
	end

	ptf_root_div u_root_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rd_ctl),
		.x      (rd_x),
		.den    (rd_den),
		.done   (rd_done),
		.res    (rd_res)
	);

	assign q16      = (rd_res > 32'(UNIT_NRM)) ? 16'(UNIT_NRM) : rd_res[15:0];
	assign push_ok  = !ovld_q || vertex_ready;
	// The output register is loaded from the finished vertex, or from the
	// held first vertex once the end vertex has passed the length test.
	assign out_load = push_ok &&
	                  ((st_q == S_OUT) || ((st_q == S_LOADT) && idx_q && pend_q));
	assign accept   = point_valid && point_ready;
	assign cfg_wr   = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_MIN_TSQ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			ph_q      <= PH_TSQ;
			k_q       <= '0;
			c_q       <= '0;
			idx_q     <= 1'b0;
			pend_q    <= 1'b0;
			scv_q     <= 1'b0;
			seen_q    <= '0;
			nv_q      <= 1'b0;
			vcnt_q    <= '0;
			min_tsq_q <= MIN_TSQ_RST;
			ovld_q    <= 1'b0;
			in_q      <= '0;
			mid_col_q <= '0;
			ecol_q    <= '0;
			tt_q      <= '0;
			pt_q      <= '0;
			len_q     <= '0;
			sg_q      <= '0;
			res_q     <= '0;
			out_q     <= '0;
			for (int i = 0; i < 3; i++) begin
				old_q[i]   <= '0;
				mid_q[i]   <= '0;
				prior_q[i] <= '0;
				t_q[i]     <= '0;
				epos_q[i]  <= '0;
				u_q[i]     <= '0;
				mg_q[i]    <= '0;
				n_q[i]     <= '0;
			end
		end else begin
			if (cfg_wr) begin
				min_tsq_q <= pwdata;
			end
			if (out_load) begin
				ovld_q <= 1'b1;
			end else if (vertex_ready) begin
				ovld_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						in_q   <= point;
						idx_q  <= 1'b0;
						pend_q <= 1'b0;
						st_q   <= S_TAN;
					end
				end
				S_TAN: begin
					if (idx_q) begin
						for (int i = 0; i < 3; i++) begin
							t_q[i]    <= tan_c[i];
							epos_q[i] <= p_in[i];
						end
						ecol_q <= in_q.color_rgb;
						st_q   <= S_CHK;
					end else if (seen_q == 2'd0) begin
						// First point of a polyline is only held.
						for (int i = 0; i < 3; i++) begin
							mid_q[i] <= p_in[i];
						end
						mid_col_q <= in_q.color_rgb;
						seen_q    <= in_q.last_point ? 2'd0 : 2'd1;
						if (in_q.last_point) begin
							nv_q <= 1'b0;
						end
						st_q <= S_IDLE;
					end else begin
						for (int i = 0; i < 3; i++) begin
							t_q[i]    <= tan_c[i];
							epos_q[i] <= mid_q[i];
							old_q[i]  <= mid_q[i];
							mid_q[i]  <= p_in[i];
						end
						ecol_q    <= mid_col_q;
						mid_col_q <= in_q.color_rgb;
						if (!nv_q) begin
							if (mag32(tan_c[1]) > mag32(tan_c[2])) begin
								prior_q[0] <= '0;
								prior_q[1] <= '0;
								prior_q[2] <= UNIT_NRM;
							end else begin
								prior_q[0] <= UNIT_NRM;
								prior_q[1] <= '0;
								prior_q[2] <= '0;
							end
						end
						nv_q   <= !in_q.last_point;
						seen_q <= in_q.last_point ? 2'd0 : 2'd2;
						st_q   <= S_CHK;
					end
				end
				S_CHK: begin
					if (small_c) begin
						ph_q <= PH_TSQ;
						k_q  <= '0;
						st_q <= S_MAC;
					end else begin
						st_q <= S_LOADT;
					end
				end
				S_MAC: begin
					k_q <= mac_end ? 3'd0 : k_q + 3'd1;
					if (mac_end) begin
						case (ph_q)
							PH_TSQ: begin
								st_q <= (acc[63:0] < 64'(min_tsq_q)) ? S_SKIP : S_LOADT;
							end
							PH_USQ: begin
								tt_q <= acc[31:0];
								ph_q <= PH_PU;
							end
							PH_PU: begin
								pt_q <= acc[31:0];
								ph_q <= PH_V;
								c_q  <= '0;
							end
							PH_V: begin
								sg_q[c_q] <= acc[ACC_W-1];
								mg_q[c_q] <= acc_mag[MAG_W-1:0];
								if (c_q == 2'd2) begin
									scv_q <= 1'b1;
									st_q  <= S_SCALE;
								end else begin
									c_q <= c_q + 2'd1;
								end
							end
							PH_VSQ: begin
								st_q <= S_ROOT;
							end
							default: begin
								st_q <= S_IDLE;
							end
						endcase
					end
				end
				S_LOADT: begin
					// The held first vertex goes out once the second is known
					// to survive the length test.
					if (idx_q && pend_q) begin
						if (push_ok) begin
							out_q  <= res_q;
							pend_q <= 1'b0;
						end
					end else begin
						for (int i = 0; i < 3; i++) begin
							sg_q[i] <= t_q[i][31];
							mg_q[i] <= MAG_W'(mag32(t_q[i]));
						end
						scv_q <= 1'b0;
						st_q  <= S_SCALE;
					end
				end
				S_SCALE: begin
					if (zero_c) begin
						st_q <= S_KEEP;
					end else if (hi_c) begin
						for (int i = 0; i < 3; i++) begin
							mg_q[i] <= mg_q[i] >> 1;
						end
					end else if (lo_c) begin
						for (int i = 0; i < 3; i++) begin
							mg_q[i] <= mg_q[i] << 1;
						end
					end else if (!scv_q) begin
						for (int i = 0; i < 3; i++) begin
							u_q[i] <= sg_q[i] ? -$signed({1'b0, mg_q[i][14:0]})
							                  : $signed({1'b0, mg_q[i][14:0]});
						end
						ph_q <= PH_USQ;
						k_q  <= '0;
						st_q <= S_MAC;
					end else begin
						ph_q <= PH_VSQ;
						k_q  <= '0;
						st_q <= S_MAC;
					end
				end
				S_ROOT: begin
					if (rd_done) begin
						len_q <= rd_res;
						c_q   <= '0;
						st_q  <= S_DIV;
					end
				end
				S_DIV: begin
					if (rd_done) begin
						n_q[c_q] <= sg_q[c_q] ? -$signed(q16) : $signed(q16);
						if (c_q == 2'd2) begin
							st_q <= S_RES;
						end else begin
							c_q <= c_q + 2'd1;
						end
					end
				end
				S_KEEP: begin
					for (int i = 0; i < 3; i++) begin
						n_q[i] <= prior_q[i];
					end
					st_q <= S_RES;
				end
				S_RES: begin
					res_q.out_x        <= epos_q[0];
					res_q.out_y        <= epos_q[1];
					res_q.out_z        <= epos_q[2];
					res_q.tan_x        <= t_q[0];
					res_q.tan_y        <= t_q[1];
					res_q.tan_z        <= t_q[2];
					res_q.nrm_x        <= n_q[0];
					res_q.nrm_y        <= n_q[1];
					res_q.nrm_z        <= n_q[2];
					res_q.vertex_color <= ecol_q;
					res_q.vertex_index <= vcnt_q;
					res_q.last_vertex  <= idx_q;
					for (int i = 0; i < 3; i++) begin
						prior_q[i] <= n_q[i];
					end
					vcnt_q <= vcnt_q + IDX_W'(1);
					if (!idx_q && in_q.last_point) begin
						idx_q  <= 1'b1;
						pend_q <= 1'b1;
						st_q   <= S_TAN;
					end else begin
						st_q <= S_OUT;
					end
				end
				S_SKIP: begin
					if (!idx_q) begin
						if (in_q.last_point) begin
							idx_q  <= 1'b1;
							pend_q <= 1'b0;
							st_q   <= S_TAN;
						end else begin
							st_q <= S_IDLE;
						end
					end else if (pend_q) begin
						// The end vertex was dropped: the held one is the last.
						res_q.last_vertex <= 1'b1;
						pend_q            <= 1'b0;
						st_q              <= S_OUT;
					end else begin
						st_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (push_ok) begin
						out_q <= res_q;
						st_q  <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign point_ready  = (st_q == S_IDLE);
	assign vertex_valid = ovld_q;
	assign vertex       = out_q;
	assign pready       = 1'b1;
	assign prdata       = (paddr[PADDR_W-1] == REG_MIN_TSQ) ? min_tsq_q : 32'd0;

	`PTF_ASSERT_NXT(a_busy_after_accept, accept, !point_ready, "point taken while busy")
	`PTF_ASSERT_IMP(a_rd_done_waited, rd_done, (st_q == S_ROOT) || (st_q == S_DIV), "root/divide result not awaited")
	`PTF_ASSERT_IMP(a_seen_legal, 1'b1, seen_q != 2'd3, "point count out of range")
	`PTF_ASSERT_IMP(a_nrm_range, vertex_valid, ($signed(vertex.nrm_x) <= 16384) && ($signed(vertex.nrm_x) >= -16384), "normal x out of range")

endmodule
